### rtl/rotation_matrix_to_quaternion_assert.svh
// assertion macros for the rotation matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`ifndef SYNTH
`define RMQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmq implication check failed");
`define RMQ_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("rmq forbidden condition seen");
`else
`define RMQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RMQ_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

### rtl/rmq_pkg.sv
// shared types and constants for the rotation matrix to quaternion block
package rmq_pkg;
    localparam int FRAC_BITS  = 14;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int IN_W       = 16;
    localparam int NUM_W      = IN_W + 2;
    localparam int MAG_W      = IN_W + 1;
    localparam int ARG_W      = 17;
    localparam int ROOT_W     = 17;
    localparam int SQ_STAGES  = ROOT_W;
    localparam int SQ_V_W     = 2 * ROOT_W;
    localparam int SQ_REM_W   = ROOT_W + 4;
    localparam int Q_W        = 16;
    localparam int DIV_W      = MAG_W + FRAC_BITS;
    localparam int CMP_W      = ROOT_W + Q_W;
    localparam int DIV_STAGES = Q_W;
    localparam int LATENCY    = 1 + SQ_STAGES + 1 + DIV_STAGES + 1;

    typedef enum logic [1:0] {BR_W, BR_X, BR_Y, BR_Z} t_branch;

    typedef struct packed {
        logic signed [IN_W-1:0] m00;
        logic signed [IN_W-1:0] m01;
        logic signed [IN_W-1:0] m02;
        logic signed [IN_W-1:0] m10;
        logic signed [IN_W-1:0] m11;
        logic signed [IN_W-1:0] m12;
        logic signed [IN_W-1:0] m20;
        logic signed [IN_W-1:0] m21;
        logic signed [IN_W-1:0] m22;
    } t_in;

    typedef struct packed {
        logic signed [IN_W-1:0] quat_w;
        logic signed [IN_W-1:0] quat_x;
        logic signed [IN_W-1:0] quat_y;
        logic signed [IN_W-1:0] quat_z;
        logic                   out_of_range;
    } t_out;

    typedef struct packed {
        logic [ARG_W-1:0]           arg;
        logic                       arg_ok;
        t_branch                    branch;
        logic [2:0][NUM_W-1:0]      num;
    } t_front;

    typedef struct packed {
        logic [ROOT_W-1:0] s;
        logic [Q_W-1:0]    diag;
        logic              bad;
        t_branch           branch;
        logic [2:0]        neg;
    } t_side;
endpackage

### rtl/rmq_front.sv
// axis flip, branch choice, sqrt argument and numerators
module rmq_front import rmq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_vld,
    input  t_in    i_item,
    output logic   o_vld,
    output t_front o_front
);
    logic signed [NUM_W-1:0] w_x1, w_y2, w_z3, w_tr;
    logic signed [NUM_W:0]   w_arg;
    t_front n_front;
    t_front r_front;
    logic   r_vld;

    assign w_x1 = NUM_W'(i_item.m00);
    assign w_y2 = NUM_W'(i_item.m11);
    assign w_z3 = NUM_W'(i_item.m22);
    assign w_tr = w_x1 + w_y2 + w_z3;

    always_comb begin
        if (w_tr > 0) begin
            n_front.branch = BR_W;
            w_arg = (NUM_W+1)'(ONE) + (NUM_W+1)'(w_tr);
            n_front.num[0] = NUM_W'(i_item.m12) - NUM_W'(i_item.m21);
            n_front.num[1] = NUM_W'(i_item.m20) - NUM_W'(i_item.m02);
            n_front.num[2] = NUM_W'(i_item.m10) - NUM_W'(i_item.m01);
        end else if (i_item.m00 > i_item.m11 && i_item.m00 > i_item.m22) begin
            n_front.branch = BR_X;
            w_arg = (NUM_W+1)'(ONE) + (NUM_W+1)'(w_x1) - (NUM_W+1)'(w_y2)
                  - (NUM_W+1)'(w_z3);
            n_front.num[0] = NUM_W'(i_item.m12) - NUM_W'(i_item.m21);
            n_front.num[1] = NUM_W'(i_item.m01) + NUM_W'(i_item.m10);
            n_front.num[2] = -(NUM_W'(i_item.m02) + NUM_W'(i_item.m20));
        end else if (i_item.m11 > i_item.m22) begin
            n_front.branch = BR_Y;
            w_arg = (NUM_W+1)'(ONE) + (NUM_W+1)'(w_y2) - (NUM_W+1)'(w_x1)
                  - (NUM_W+1)'(w_z3);
            n_front.num[0] = NUM_W'(i_item.m20) - NUM_W'(i_item.m02);
            n_front.num[1] = NUM_W'(i_item.m01) + NUM_W'(i_item.m10);
            n_front.num[2] = -(NUM_W'(i_item.m12) + NUM_W'(i_item.m21));
        end else begin
            n_front.branch = BR_Z;
            w_arg = (NUM_W+1)'(ONE) + (NUM_W+1)'(w_z3) - (NUM_W+1)'(w_x1)
                  - (NUM_W+1)'(w_y2);
            n_front.num[0] = NUM_W'(i_item.m10) - NUM_W'(i_item.m01);
            n_front.num[1] = -(NUM_W'(i_item.m02) + NUM_W'(i_item.m20));
            n_front.num[2] = -(NUM_W'(i_item.m12) + NUM_W'(i_item.m21));
        end
        n_front.arg_ok = (w_arg > 0);
        n_front.arg    = n_front.arg_ok ? w_arg[ARG_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
    end

    assign o_vld   = r_vld;
    assign o_front = r_front;
endmodule

### rtl/rmq_sqrt.sv
// pipelined integer square root, one root bit per stage
module rmq_sqrt import rmq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  t_front            i_front,
    output logic              o_vld,
    output t_front            o_front,
    output logic [ROOT_W-1:0] o_root
);
    logic [SQ_REM_W-1:0] w_rem_in [SQ_STAGES];
    logic [ROOT_W-1:0]   w_root_in [SQ_STAGES];
    logic [SQ_V_W-1:0]   w_v_in [SQ_STAGES];
    t_front              w_fr_in [SQ_STAGES];
    logic                w_vld_in [SQ_STAGES];
    logic [SQ_REM_W-1:0] w_sh [SQ_STAGES];
    logic [SQ_REM_W-1:0] w_trial [SQ_STAGES];
    logic                w_ge [SQ_STAGES];
    logic [SQ_REM_W-1:0] n_rem [SQ_STAGES];
    logic [ROOT_W-1:0]   n_root [SQ_STAGES];
    logic [SQ_V_W-1:0]   n_v [SQ_STAGES];
    logic [SQ_REM_W-1:0] r_rem [SQ_STAGES];
    logic [ROOT_W-1:0]   r_root [SQ_STAGES];
    logic [SQ_V_W-1:0]   r_v [SQ_STAGES];
    t_front              r_fr [SQ_STAGES];
    logic                r_vld [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign w_rem_in[k]  = '0;
            assign w_root_in[k] = '0;
            assign w_v_in[k]    = {{(SQ_V_W-ARG_W-FRAC_BITS-2){1'b0}}, i_front.arg,
                                   {(FRAC_BITS+2){1'b0}}};
            assign w_fr_in[k]   = i_front;
            assign w_vld_in[k]  = i_vld;
        end else begin : g_next
            assign w_rem_in[k]  = r_rem[k-1];
            assign w_root_in[k] = r_root[k-1];
            assign w_v_in[k]    = r_v[k-1];
            assign w_fr_in[k]   = r_fr[k-1];
            assign w_vld_in[k]  = r_vld[k-1];
        end

        // bring down the next two bits, try root*4+1
        assign w_sh[k]    = {w_rem_in[k][SQ_REM_W-3:0], w_v_in[k][SQ_V_W-1 -: 2]};
        assign w_trial[k] = SQ_REM_W'({w_root_in[k], 2'b01});
        assign w_ge[k]    = (w_sh[k] >= w_trial[k]);
        assign n_rem[k]   = w_ge[k] ? (w_sh[k] - w_trial[k]) : w_sh[k];
        assign n_root[k]  = {w_root_in[k][ROOT_W-2:0], w_ge[k]};
        assign n_v[k]     = {w_v_in[k][SQ_V_W-3:0], 2'b00};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
            r_v[k]    <= n_v[k];
            r_fr[k]   <= w_fr_in[k];
        end
    end

    assign o_vld   = r_vld[SQ_STAGES-1];
    assign o_front = r_fr[SQ_STAGES-1];
    assign o_root  = r_root[SQ_STAGES-1];
endmodule

### rtl/rmq_div.sv
// three-lane pipelined restoring divider, one quotient bit per stage
module rmq_div import rmq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  t_side                 i_side,
    input  logic [2:0][DIV_W-1:0] i_dvd,
    output logic                  o_vld,
    output t_side                 o_side,
    output logic [2:0][Q_W-1:0]   o_q,
    output logic [2:0]            o_ovf
);
    logic [2:0][DIV_W-1:0] w_rem_in [DIV_STAGES];
    logic [2:0][Q_W-1:0]   w_q_in [DIV_STAGES];
    logic [2:0]            w_ovf_in [DIV_STAGES];
    t_side                 w_side_in [DIV_STAGES];
    logic                  w_vld_in [DIV_STAGES];
    logic [2:0][DIV_W-1:0] n_rem [DIV_STAGES];
    logic [2:0][Q_W-1:0]   n_q [DIV_STAGES];
    logic [2:0]            n_ovf [DIV_STAGES];
    logic [2:0][DIV_W-1:0] r_rem [DIV_STAGES];
    logic [2:0][Q_W-1:0]   r_q [DIV_STAGES];
    logic [2:0]            r_ovf [DIV_STAGES];
    t_side                 r_side [DIV_STAGES];
    logic                  r_vld [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
        localparam int B = Q_W - 1 - j;

        if (j == 0) begin : g_first
            assign w_rem_in[j]  = i_dvd;
            assign w_q_in[j]    = '0;
            assign w_ovf_in[j]  = '0;
            assign w_side_in[j] = i_side;
            assign w_vld_in[j]  = i_vld;
        end else begin : g_next
            assign w_rem_in[j]  = r_rem[j-1];
            assign w_q_in[j]    = r_q[j-1];
            assign w_ovf_in[j]  = r_ovf[j-1];
            assign w_side_in[j] = r_side[j-1];
            assign w_vld_in[j]  = r_vld[j-1];
        end

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [CMP_W-1:0] w_ext;
            logic [CMP_W-1:0] w_sub;
            logic             w_ge;

            assign w_ext = CMP_W'(w_rem_in[j][l]);
            assign w_sub = CMP_W'(w_side_in[j].s) << B;
            assign w_ge  = (w_ext >= w_sub);
            assign n_rem[j][l] = w_ge ? DIV_W'(w_ext - w_sub) : w_rem_in[j][l];
            assign n_q[j][l]   = w_q_in[j][l] | (Q_W'(w_ge) << B);
            if (j == 0) begin : g_ovf
                // quotient would need more than Q_W bits
                assign n_ovf[j][l] = (w_ext >= {w_side_in[j].s, {Q_W{1'b0}}});
            end else begin : g_keep
                assign n_ovf[j][l] = w_ovf_in[j][l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= w_vld_in[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j]  <= n_rem[j];
            r_q[j]    <= n_q[j];
            r_ovf[j]  <= n_ovf[j];
            r_side[j] <= w_side_in[j];
        end
    end

    assign o_vld  = r_vld[DIV_STAGES-1];
    assign o_side = r_side[DIV_STAGES-1];
    assign o_q    = r_q[DIV_STAGES-1];
    assign o_ovf  = r_ovf[DIV_STAGES-1];
endmodule

### rtl/rotation_matrix_to_quaternion.sv
// top level: rotation matrix to quaternion, fully pipelined
// an accepted item passes the front, square root, prep, divider and output registers before the o_valid strobe
// throughput: one item per cycle, busy stays low; the 17-stage square root
// and the 16-stage three-lane divider set the depth
// reset (synchronous, active low) empties the pipeline; no strobe until refilled
// results show for one cycle only, the receiver cannot stall
`include "rotation_matrix_to_quaternion_assert.svh"
module rotation_matrix_to_quaternion import rmq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_valid,
    output t_out o_result
);
    logic                  w_acc;
    logic                  w_fr_vld;
    t_front                w_front;
    logic                  w_sq_vld;
    t_front                w_sq_front;
    logic [ROOT_W-1:0]     w_root;
    logic [ROOT_W:0]       w_diag_sum;
    t_side                 n_side;
    logic [2:0][DIV_W-1:0] n_dvd;
    t_side                 r_side;
    logic [2:0][DIV_W-1:0] r_dvd;
    logic                  r_prep_vld;
    logic                  w_dv_vld;
    t_side                 w_dv_side;
    logic [2:0][Q_W-1:0]   w_q;
    logic [2:0]            w_ovf;
    t_out                  n_res;
    t_out                  r_res;
    logic                  r_vld;

    // never stalls: a new matrix every cycle
    assign busy  = 1'b0;
    assign w_acc = start & ~busy;

    // stage 1: flip, trace, branch, numerators
    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_acc),
        .i_item  (i_item),
        .o_vld   (w_fr_vld),
        .o_front (w_front)
    );

    // stages 2..18: S = floor(sqrt(arg << (FRAC_BITS+2)))
    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_fr_vld),
        .i_front (w_front),
        .o_vld   (w_sq_vld),
        .o_front (w_sq_front),
        .o_root  (w_root)
    );

    // stage 19: diagonal term S/4 rounded, dividends |num|<<FRAC_BITS + S/2
    assign w_diag_sum = {1'b0, w_root} + (ROOT_W+1)'(2);

    always_comb begin
        logic signed [NUM_W-1:0] num;
        logic [NUM_W-1:0]        mag;
        n_side.s      = w_root;
        n_side.diag   = w_diag_sum[ROOT_W -: Q_W];
        n_side.branch = w_sq_front.branch;
        // non-positive argument, zero root (guard) or diagonal above one rejects the item
        n_side.bad    = !w_sq_front.arg_ok || (w_root == '0)
                      || (n_side.diag > Q_W'(ONE));
        for (int l = 0; l < 3; l++) begin
            num = $signed(w_sq_front.num[l]);
            mag = (num < 0) ? NUM_W'(-num) : NUM_W'(num);
            n_side.neg[l] = (num < 0);
            n_dvd[l] = {mag[MAG_W-1:0], {FRAC_BITS{1'b0}}}
                     + DIV_W'(w_root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_vld <= 1'b0;
        end else begin
            r_prep_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= n_side;
        r_dvd  <= n_dvd;
    end

    // stages 20..35: three off-diagonal quotients in parallel
    rmq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_prep_vld),
        .i_side  (r_side),
        .i_dvd   (r_dvd),
        .o_vld   (w_dv_vld),
        .o_side  (w_dv_side),
        .o_q     (w_q),
        .o_ovf   (w_ovf)
    );

    // stage 36: range check, place components by branch, conjugate
    always_comb begin
        logic signed [Q_W:0] lane [3];
        logic signed [Q_W:0] comp [4];
        logic signed [Q_W:0] neg_x, neg_y, neg_z;
        logic                bad;
        bad = w_dv_side.bad;
        for (int l = 0; l < 3; l++) begin
            lane[l] = w_dv_side.neg[l] ? -$signed({1'b0, w_q[l]}) : $signed({1'b0, w_q[l]});
            bad = bad | w_ovf[l] | (w_q[l] > Q_W'(ONE));
        end
        unique case (w_dv_side.branch)
            BR_W: begin
                comp[0] = $signed({1'b0, w_dv_side.diag});
                comp[1] = lane[0];
                comp[2] = lane[1];
                comp[3] = lane[2];
            end
            BR_X: begin
                comp[0] = lane[0];
                comp[1] = $signed({1'b0, w_dv_side.diag});
                comp[2] = lane[1];
                comp[3] = lane[2];
            end
            BR_Y: begin
                comp[0] = lane[0];
                comp[1] = lane[1];
                comp[2] = $signed({1'b0, w_dv_side.diag});
                comp[3] = lane[2];
            end
            default: begin
                comp[0] = lane[0];
                comp[1] = lane[1];
                comp[2] = lane[2];
                comp[3] = $signed({1'b0, w_dv_side.diag});
            end
        endcase
        neg_x = -comp[1];
        neg_y = -comp[2];
        neg_z = -comp[3];
        n_res.out_of_range = bad;
        n_res.quat_w = bad ? '0 : comp[0][IN_W-1:0];
        n_res.quat_x = bad ? '0 : neg_x[IN_W-1:0];
        n_res.quat_y = bad ? '0 : neg_y[IN_W-1:0];
        n_res.quat_z = bad ? '0 : neg_z[IN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid  = r_vld;
    assign o_result = r_res;

    // every strobe traces back to an accepted item
    `RMQ_ASSERT_IMPLY(a_latency, i_clk, i_rst_n, o_valid, $past(start && !busy, LATENCY))
    // a rejected item carries all-zero parts
    `RMQ_ASSERT_IMPLY(a_reject_zero, i_clk, i_rst_n, o_valid && o_result.out_of_range, o_result.quat_w == '0 && o_result.quat_x == '0 && o_result.quat_y == '0 && o_result.quat_z == '0)
    // accepted scalar part stays within plus or minus one
    `RMQ_ASSERT_IMPLY(a_w_range, i_clk, i_rst_n, o_valid && !o_result.out_of_range, $signed(o_result.quat_w) <= ONE && $signed(o_result.quat_w) >= -ONE)
    // an accepted item never yields an all-zero quaternion
    `RMQ_ASSERT_NEVER(a_no_null_quat, i_clk, i_rst_n, o_valid && !o_result.out_of_range && o_result.quat_w == '0 && o_result.quat_x == '0 && o_result.quat_y == '0 && o_result.quat_z == '0)
endmodule
